[hw/rtl/can_fragment_packet_reassembler_core_assert.svh]
// Assertion macros shared by the reassembler RTL.
// Used by modules that have clk_i and rst_ni; define ASSERT_OFF to drop them.
`ifndef CAN_FRAGMENT_PACKET_REASSEMBLER_CORE_ASSERT_SVH
`define CAN_FRAGMENT_PACKET_REASSEMBLER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("reassembler assertion failed");
`define CFRM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("reassembler forbidden condition seen");
`else
`define CFRM_ASSERT(lbl, prop)
`define CFRM_NEVER(lbl, cond)
`endif

`endif

[hw/rtl/cfrm_pkg.sv]
// Shared types and constants of the CAN fragment reassembler.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package cfrm_pkg;

  localparam int MAX_PACKET_BYTES = 1024;

  localparam int FRAME_ID_W = 29;
  localparam int CHAN_W     = 16;
  localparam int CHAN_LSB   = 12;
  localparam int CNT_W      = 4;
  localparam int DATA_W     = 64;
  localparam int NBYTES     = 8;
  localparam int LEN_W      = 11;
  localparam int OFF_W      = 10;
  localparam int EP_W       = 6;
  localparam int FRAG_W     = 7;
  localparam int NFRAG_W    = 8;
  localparam int OP_W       = 8;
  localparam int PHASE_W    = 3;
  localparam int STATUS_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_CHANNEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 2'd1;

  localparam logic [OP_W-1:0] OP_LEAD_MAX = 8'h3f;
  localparam logic [OP_W-1:0] OP_DATA_MIN = 8'h40;
  localparam logic [OP_W-1:0] OP_DATA_MAX = 8'hbf;
  localparam logic [OP_W-1:0] OP_TRAIL    = 8'hc0;
  localparam logic [OP_W-1:0] OP_ADV      = 8'hc1;

  localparam logic [PHASE_W-1:0] PH_READY    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DATA     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TRAILING = 3'd2;
  localparam logic [PHASE_W-1:0] PH_INVALID  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OPC_LEAD,
    OPC_DATA,
    OPC_TRAIL,
    OPC_ADV,
    OPC_OTHER
  } op_class_e;

  // Classified frame handed from front to back
  typedef struct packed {
    logic              match;
    op_class_e         op_class;
    logic [FRAG_W-1:0] frag;
    logic [EP_W-1:0]   endpoint;
    logic              len_ok;
    logic [LEN_W-1:0]  lead_len;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHASE_W-1:0]  rx_phase;
    logic                write_enable;
    logic [OFF_W-1:0]    write_offset;
    logic [DATA_W-1:0]   write_data;
    logic [CNT_W-1:0]    write_count;
    logic                packet_done;
    logic [EP_W-1:0]     endpoint;
    logic [LEN_W-1:0]    packet_length;
  } result_t;

endpackage

[hw/rtl/can_fragment_packet_reassembler_core.sv]
// CAN fragment packet reassembler. One received CAN frame enters per push and
// yields exactly one result, in order. Items flow through a front end (channel
// filter match, byte-count clamp, opcode decode), a two-entry queue and a back
// end that owns the reassembly phase, lengths, fragment number and lost flag.
// Throughput is one item per clock while results are popped: the back end
// refills its output register in the cycle it is popped. An accepted item is
// written into the queue and then moves into the output register, where the
// result shows (empty low), once the back end can take it. full rises only
// when the queue is full and the result register is still waiting to be
// popped. Configuration writes are always taken (cfg_ready_o is tied high)
// and must only be issued while idle; writing own_channel clears the lost
// flag set by an advertisement frame.
// Depends on cfrm_pkg, cfrm_front, cfrm_queue and cfrm_back.
`timescale 1ns / 1ps

module can_fragment_packet_reassembler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // frame input queue side
  input  logic                                push,
  output logic                                full,
  input  logic [cfrm_pkg::FRAME_ID_W-1:0]     frame_id_i,
  input  logic                                extended_i,
  input  logic [cfrm_pkg::CNT_W-1:0]          byte_count_i,
  input  logic [cfrm_pkg::DATA_W-1:0]         payload_i,
  // result queue side
  output logic                                empty,
  input  logic                                pop,
  output logic [cfrm_pkg::STATUS_W-1:0]       status_o,
  output logic [cfrm_pkg::PHASE_W-1:0]        rx_phase_o,
  output logic                                write_enable_o,
  output logic [cfrm_pkg::OFF_W-1:0]          write_offset_o,
  output logic [cfrm_pkg::DATA_W-1:0]         write_data_o,
  output logic [cfrm_pkg::CNT_W-1:0]          write_count_o,
  output logic                                packet_done_o,
  output logic [cfrm_pkg::EP_W-1:0]           endpoint_o,
  output logic [cfrm_pkg::LEN_W-1:0]          packet_length_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cfrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cfrm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cfrm_pkg::*;

  item_t   fe_item;
  item_t   q_item;
  result_t res;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  logic    lost_clr;
  logic    out_valid;
  logic    pop_acc;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign empty       = !out_valid;
  assign pop_acc     = pop && out_valid;

  cfrm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .q_full_i     (q_full),
    .frame_id_i   (frame_id_i),
    .extended_i   (extended_i),
    .byte_count_i (byte_count_i),
    .payload_i    (payload_i),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_push_o     (q_push),
    .item_o       (fe_item),
    .lost_clr_o   (lost_clr)
  );

  cfrm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_item_i (fe_item),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  cfrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .item_i      (q_item),
    .q_pop_o     (q_pop),
    .lost_clr_i  (lost_clr),
    .pop_i       (pop_acc),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign status_o        = res.status;
  assign rx_phase_o      = res.rx_phase;
  assign write_enable_o  = res.write_enable;
  assign write_offset_o  = res.write_offset;
  assign write_data_o    = res.write_data;
  assign write_count_o   = res.write_count;
  assign packet_done_o   = res.packet_done;
  assign endpoint_o      = res.endpoint;
  assign packet_length_o = res.packet_length;

endmodule

[hw/rtl/cfrm_queue.sv]
// Short register queue carrying classified items from front to back.
// Depends on cfrm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "can_fragment_packet_reassembler_core_assert.svh"

module cfrm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  cfrm_pkg::item_t wr_item_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output cfrm_pkg::item_t rd_item_o,
  output logic           empty_o
);
  import cfrm_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  `CFRM_NEVER(a_no_write_when_full, wr_en_i && full_o)
  `CFRM_NEVER(a_no_read_when_empty, rd_en_i && empty_o)
  `CFRM_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH))

endmodule

[hw/rtl/cfrm_front.sv]
// Front end: holds the configuration registers, accepts frames and classifies them.
// Depends on cfrm_pkg.
`timescale 1ns / 1ps

module cfrm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                q_full_i,
  input  logic [cfrm_pkg::FRAME_ID_W-1:0]     frame_id_i,
  input  logic                                extended_i,
  input  logic [cfrm_pkg::CNT_W-1:0]          byte_count_i,
  input  logic [cfrm_pkg::DATA_W-1:0]         payload_i,
  input  logic                                cfg_valid_i,
  input  logic [cfrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cfrm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                q_push_o,
  output cfrm_pkg::item_t                     item_o,
  output logic                                lost_clr_o
);
  import cfrm_pkg::*;

  logic [CHAN_W-1:0] own_channel_q;
  logic              channel_enable_q;
  logic [OP_W-1:0]   op;
  logic [OP_W-1:0]   frag_full;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] data;
  logic [15:0]       len16;

  assign lost_clr_o = cfg_valid_i && (cfg_index_i == CFG_OWN_CHANNEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_channel_q    <= '0;
      channel_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_OWN_CHANNEL) begin
        own_channel_q <= cfg_data_i[CHAN_W-1:0];
      end
      if (cfg_index_i == CFG_CHANNEL_ENABLE) begin
        channel_enable_q <= cfg_data_i[0];
      end
    end
  end

  assign q_push_o = push_i && !q_full_i;

  // Clamp the count to eight and zero bytes beyond it
  always_comb begin
    cnt = (byte_count_i > CNT_W'(NBYTES)) ? CNT_W'(NBYTES) : byte_count_i;
    for (int i = 0; i < NBYTES; i++) begin
      data[8*i +: 8] = (CNT_W'(i) < cnt) ? payload_i[8*i +: 8] : 8'h00;
    end
  end

  assign op        = frame_id_i[OP_W-1:0];
  assign frag_full = op - OP_DATA_MIN;
  assign len16     = data[47:32];

  always_comb begin
    item_o.match    = extended_i && channel_enable_q &&
                      (frame_id_i[CHAN_LSB +: CHAN_W] == own_channel_q);
    if (op <= OP_LEAD_MAX) begin
      item_o.op_class = OPC_LEAD;
    end else if (op <= OP_DATA_MAX) begin
      item_o.op_class = OPC_DATA;
    end else if (op == OP_TRAIL) begin
      item_o.op_class = OPC_TRAIL;
    end else if (op == OP_ADV) begin
      item_o.op_class = OPC_ADV;
    end else begin
      item_o.op_class = OPC_OTHER;
    end
    item_o.frag     = frag_full[FRAG_W-1:0];
    item_o.endpoint = op[EP_W-1:0];
    item_o.len_ok   = ({1'b0, len16} <= 17'(MAX_PACKET_BYTES));
    item_o.lead_len = len16[LEN_W-1:0];
    item_o.cnt      = cnt;
    item_o.data     = data;
  end

endmodule

[hw/rtl/cfrm_back.sv]
// Back end: reassembly state of the own channel; applies one classified item per cycle while the result is popped.
// Depends on cfrm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "can_fragment_packet_reassembler_core_assert.svh"

module cfrm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  cfrm_pkg::item_t   item_i,
  output logic              q_pop_o,
  input  logic              lost_clr_i,
  input  logic              pop_i,
  output logic              out_valid_o,
  output cfrm_pkg::result_t res_o
);
  import cfrm_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0]   exp_q, exp_d;
  logic [LEN_W-1:0]   rcv_q, rcv_d;
  logic [NFRAG_W-1:0] nfrag_q, nfrag_d;
  logic [EP_W-1:0]    ep_q, ep_d;
  logic               lost_q;
  logic               set_lost;
  logic               ignored;
  logic [LEN_W:0]     sum;
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               take;

  assign take        = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign ignored     = !item_i.match || lost_q;
  assign sum         = (LEN_W+1)'(rcv_q) + (LEN_W+1)'(item_i.cnt);

  always_comb begin
    phase_d  = phase_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    nfrag_d  = nfrag_q;
    ep_d     = ep_q;
    set_lost = 1'b0;
    res_d    = '0;
    res_d.status = ST_OK;
    if (ignored) begin
      res_d.status = ST_IGNORED;
    end else begin
      unique case (item_i.op_class)
        OPC_LEAD: begin
          phase_d = PH_READY;
          if (!item_i.len_ok) begin
            res_d.status = ST_REJECT;
          end else begin
            rcv_d   = '0;
            exp_d   = item_i.lead_len;
            nfrag_d = '0;
            ep_d    = item_i.endpoint;
            phase_d = PH_DATA;
          end
        end
        OPC_DATA: begin
          if (phase_q != PH_DATA || nfrag_q != NFRAG_W'(item_i.frag) ||
              sum > (LEN_W+1)'(exp_q)) begin
            res_d.status = ST_REJECT;
          end else begin
            res_d.write_enable = 1'b1;
            res_d.write_offset = rcv_q[OFF_W-1:0];
            res_d.write_data   = item_i.data;
            res_d.write_count  = item_i.cnt;
            rcv_d   = sum[LEN_W-1:0];
            nfrag_d = nfrag_q + 1'b1;
            if (sum[LEN_W-1:0] == exp_q) begin
              phase_d = PH_TRAILING;
            end
          end
        end
        OPC_TRAIL: begin
          if (phase_q != PH_TRAILING) begin
            phase_d      = PH_INVALID;
            res_d.status = ST_REJECT;
          end else begin
            phase_d           = PH_DONE;
            res_d.packet_done = 1'b1;
          end
        end
        OPC_ADV: begin
          set_lost     = 1'b1;
          res_d.status = ST_CONFLICT;
        end
        OPC_OTHER: begin
          res_d.status = ST_REJECT;
        end
        default: begin
          res_d.status = ST_REJECT;
        end
      endcase
    end
    res_d.rx_phase      = phase_d;
    res_d.endpoint      = ep_d;
    res_d.packet_length = exp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_READY;
      exp_q       <= '0;
      rcv_q       <= '0;
      nfrag_q     <= '0;
      ep_q        <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        exp_q   <= exp_d;
        rcv_q   <= rcv_d;
        nfrag_q <= nfrag_d;
        ep_q    <= ep_d;
      end
      // The user must write own_channel only while idle (not enforced); lost_clr_i wins a clash with set_lost.
      if (lost_clr_i) begin
        lost_q <= 1'b0;
      end else if (take && set_lost) begin
        lost_q <= 1'b1;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  `CFRM_ASSERT(a_wen_only_ok, (out_valid_q && res_q.write_enable) |-> (res_q.status == ST_OK))
  `CFRM_ASSERT(a_done_phase, (out_valid_q && res_q.packet_done) |-> (res_q.rx_phase == PH_DONE))
  `CFRM_ASSERT(a_ignored_holds, (take && ignored) |=> ($stable(phase_q) && $stable(rcv_q)))
  `CFRM_NEVER(a_pop_overflow, take && out_valid_q && !pop_i)

endmodule

[tb/can_fragment_packet_reassembler_core_tb.sv]
// Self-checking testbench for can_fragment_packet_reassembler_core.
// Holds its own model of the reassembly state machine and checks every result item.
// Depends on cfrm_pkg and the core RTL only.
`timescale 1ns / 1ps

module can_fragment_packet_reassembler_core_tb;
  import cfrm_pkg::*;

  // One received CAN frame as pushed into the block
  typedef struct packed {
    logic [FRAME_ID_W-1:0] id;
    logic                  ext;
    logic [CNT_W-1:0]      cnt;
    logic [DATA_W-1:0]     payload;
  } frame_t;

  // Tracks the reassembly state of our channel and holds the result items owed.
  class reassembly_tracker;
    logic [CHAN_W-1:0]  own_chan;
    logic               chan_en;
    logic               lost;
    logic [PHASE_W-1:0] phase;
    logic [LEN_W-1:0]   want_len;
    logic [LEN_W-1:0]   got_len;
    logic [NFRAG_W-1:0] frag_want;
    logic [EP_W-1:0]    cur_ep;
    result_t            awaited[$];
    int                 errors;
    int                 counted;

    function new();
      own_chan  = '0;
      chan_en   = 1'b0;
      lost      = 1'b0;
      phase     = PH_READY;
      want_len  = '0;
      got_len   = '0;
      frag_want = '0;
      cur_ep    = '0;
      errors    = 0;
      counted   = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_OWN_CHANNEL) begin
        own_chan = val;
        lost     = 1'b0;
      end else if (idx == CFG_CHANNEL_ENABLE) begin
        chan_en = val[0];
      end
    endfunction

    // Works out the result item of one accepted frame and queues it.
    function void take_frame(input frame_t f);
      result_t          r;
      logic [CNT_W-1:0] n;
      logic [63:0]      d;
      logic [7:0]       op;
      logic [15:0]      len;
      logic [7:0]       frag;
      r  = '0;
      n  = (f.cnt > 4'd8) ? 4'd8 : f.cnt;
      d  = (n == 4'd8) ? f.payload : f.payload & ((64'd1 << (8 * n)) - 64'd1);
      op = f.id[7:0];
      r.status = ST_OK;
      if (!f.ext || !chan_en || lost || f.id[CHAN_LSB +: CHAN_W] != own_chan) begin
        r.status = ST_IGNORED;
      end else if (op <= OP_LEAD_MAX) begin
        len   = d[47:32];
        phase = PH_READY;
        if (int'(len) > MAX_PACKET_BYTES) begin
          r.status = ST_REJECT;
        end else begin
          got_len   = '0;
          want_len  = len[LEN_W-1:0];
          frag_want = '0;
          cur_ep    = op[EP_W-1:0];
          phase     = PH_DATA;
        end
      end else if (op <= OP_DATA_MAX) begin
        frag = op - OP_DATA_MIN;
        if (phase != PH_DATA || frag_want != frag ||
            int'(got_len) + int'(n) > int'(want_len)) begin
          r.status = ST_REJECT;
        end else begin
          r.write_enable = 1'b1;
          r.write_offset = got_len[OFF_W-1:0];
          r.write_data   = d;
          r.write_count  = n;
          got_len        = got_len + LEN_W'(n);
          frag_want      = frag_want + 8'd1;
          if (got_len == want_len) phase = PH_TRAILING;
        end
      end else if (op == OP_TRAIL) begin
        if (phase != PH_TRAILING) begin
          phase    = PH_INVALID;
          r.status = ST_REJECT;
        end else begin
          phase         = PH_DONE;
          r.packet_done = 1'b1;
        end
      end else if (op == OP_ADV) begin
        lost     = 1'b1;
        r.status = ST_CONFLICT;
      end else begin
        r.status = ST_REJECT;
      end
      r.rx_phase      = phase;
      r.endpoint      = cur_ep;
      r.packet_length = want_len;
      if (r.status != ST_IGNORED) counted++;
      awaited.push_back(r);
    endfunction

    function void field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      want = awaited.pop_front();
      field("status",        64'(want.status),        64'(got.status));
      field("rx_phase",      64'(want.rx_phase),      64'(got.rx_phase));
      field("write_enable",  64'(want.write_enable),  64'(got.write_enable));
      field("write_offset",  64'(want.write_offset),  64'(got.write_offset));
      field("write_data",    want.write_data,         got.write_data);
      field("write_count",   64'(want.write_count),   64'(got.write_count));
      field("packet_done",   64'(want.packet_done),   64'(got.packet_done));
      field("endpoint",      64'(want.endpoint),      64'(got.endpoint));
      field("packet_length", 64'(want.packet_length), 64'(got.packet_length));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [FRAME_ID_W-1:0] frame_id_i;
  logic                  extended_i;
  logic [CNT_W-1:0]      byte_count_i;
  logic [DATA_W-1:0]     payload_i;
  logic                  empty;
  logic                  pop;
  logic [STATUS_W-1:0]   status_o;
  logic [PHASE_W-1:0]    rx_phase_o;
  logic                  write_enable_o;
  logic [OFF_W-1:0]      write_offset_o;
  logic [DATA_W-1:0]     write_data_o;
  logic [CNT_W-1:0]      write_count_o;
  logic                  packet_done_o;
  logic [EP_W-1:0]       endpoint_o;
  logic [LEN_W-1:0]      packet_length_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  reassembly_tracker trk = new();

  // Idle percentages per side, changed from phase to phase by the main sequence
  int  send_idle_pct;
  int  pop_idle_pct;
  // Set by the main sequence to make the result side hold off for a long stretch
  bit  hold_req;

  can_fragment_packet_reassembler_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .frame_id_i      (frame_id_i),
    .extended_i      (extended_i),
    .byte_count_i    (byte_count_i),
    .payload_i       (payload_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .rx_phase_o      (rx_phase_o),
    .write_enable_o  (write_enable_o),
    .write_offset_o  (write_offset_o),
    .write_data_o    (write_data_o),
    .write_count_o   (write_count_o),
    .packet_done_o   (packet_done_o),
    .endpoint_o      (endpoint_o),
    .packet_length_o (packet_length_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest legal run (every gap and stall at its longest)
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one; none at all when pct is zero
  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Frame on our channel; direction and the unused id bits are left random
  function automatic frame_t own_frame(input logic [7:0] op, input logic [CNT_W-1:0] cnt,
                                       input logic [63:0] pl);
    frame_t      f;
    logic [31:0] r;
    r         = $urandom;
    f.id      = {r[0], trk.own_chan, r[2:1], r[4:3], op};
    f.ext     = 1'b1;
    f.cnt     = cnt;
    f.payload = pl;
    return f;
  endfunction

  // Bus traffic of any kind; almost always some other channel
  function automatic frame_t random_frame();
    frame_t f;
    f.id      = FRAME_ID_W'($urandom);
    f.ext     = 1'($urandom);
    f.cnt     = CNT_W'($urandom_range(0, 15));
    f.payload = rand64();
    return f;
  endfunction

  // Holds the item on the ports until the block takes it, then idles at random.
  // When the next item follows at once, push simply stays high.
  task automatic send_frame(input frame_t f);
    int gap;
    @(negedge clk_i);
    push         = 1'b1;
    frame_id_i   = f.id;
    extended_i   = f.ext;
    byte_count_i = f.cnt;
    payload_i    = f.payload;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    trk.take_frame(f);
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_own(input logic [7:0] op, input logic [CNT_W-1:0] cnt,
                          input logic [63:0] pl);
    send_frame(own_frame(op, cnt, pl));
  endtask

  // Leading frame: the packet length sits in payload bytes 4 and 5
  task automatic send_lead(input logic [EP_W-1:0] ep, input logic [15:0] len,
                           input logic [CNT_W-1:0] cnt);
    logic [63:0] pl;
    pl        = rand64();
    pl[47:32] = len;
    send_own({2'b00, ep}, cnt, pl);
  endtask

  // Lowers push, then waits until every result item owed has been popped and
  // the pipeline has surely settled.
  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (trk.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    trk.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One packet attempt: leading frame, fragments in order with random sizes,
  // trailing frame. Noise, misordered, overrunning and early frames are mixed in.
  task automatic send_packet();
    logic [EP_W-1:0]  ep;
    logic [15:0]      len;
    logic [CNT_W-1:0] cnt;
    int               rem;
    int               frag;
    int               n;
    int               r;
    bit               forced;
    ep = EP_W'($urandom_range(0, 63));
    r  = $urandom_range(0, 99);
    if (r < 3)       len = 16'($urandom_range(1025, 65535));
    else if (r == 3) len = 16'(MAX_PACKET_BYTES);
    else if (r == 4) len = 16'($urandom_range(400, 1023));
    else if (r < 20) len = 16'($urandom_range(65, 399));
    else             len = 16'($urandom_range(0, 64));
    r   = $urandom_range(0, 99);
    cnt = (r < 80) ? 4'd8 : (r < 90) ? CNT_W'($urandom_range(9, 15))
                                     : CNT_W'($urandom_range(0, 7));
    send_lead(ep, len, cnt);
    // length bytes cut off by a short byte count read as zero
    if (cnt < 4'd5)       len = '0;
    else if (cnt == 4'd5) len = {8'h00, len[7:0]};
    if (int'(len) > MAX_PACKET_BYTES) return;

    rem  = int'(len);
    frag = 0;
    while (rem > 0 || frag == 0) begin
      r = $urandom_range(0, 99);
      // fragment numbers stop at 127, so big packets must use full fragments
      forced = rem > 8 * (127 - frag);
      if (!forced && r < 4) begin
        send_frame(random_frame());
      end else if (!forced && r == 4) begin
        send_own(($urandom_range(0, 3) == 0) ? OP_ADV : 8'($urandom_range(8'hc2, 8'hff)),
                 CNT_W'($urandom_range(0, 15)), rand64());
      end else if (!forced && r < 7) begin
        // trailing frame too early: packet turns invalid
        send_own(OP_TRAIL, CNT_W'($urandom_range(0, 8)), rand64());
        return;
      end else if (!forced && r < 10) begin
        send_own(OP_DATA_MIN + 8'((frag + $urandom_range(1, 127)) % 128),
                 CNT_W'($urandom_range(0, 8)), rand64());
      end else if (!forced && r < 13 && rem < 8) begin
        // fragment longer than what is left: rejected, nothing advances
        send_own(OP_DATA_MIN + 8'(frag), CNT_W'($urandom_range(rem + 1, 8)), rand64());
      end else begin
        if (forced || rem == 0)  n = (rem < 8) ? rem : 8;
        else if (r < 16)         n = 0;
        else if (r < 60)         n = (rem < 8) ? rem : 8;
        else                     n = $urandom_range(1, (rem < 8) ? rem : 8);
        send_own(OP_DATA_MIN + 8'(frag), CNT_W'(n), rand64());
        rem  = rem - n;
        frag = frag + 1;
      end
    end

    r = $urandom_range(0, 99);
    if (r < 5) send_own(OP_DATA_MIN + 8'(frag), CNT_W'($urandom_range(0, 8)), rand64());
    if (r < 92) send_own(OP_TRAIL, CNT_W'($urandom_range(0, 15)), rand64());
  endtask

  // Packets until the given number of frames have got past the filter. A channel
  // lost to an advertisement is won back by rewriting own_channel while idle.
  task automatic run_packets(input int target);
    while (trk.counted < target) begin
      if (trk.lost) begin
        wait_drained();
        write_reg(CFG_OWN_CHANNEL, trk.own_chan);
      end
      send_packet();
    end
  endtask

  // Result side: pops with random stalls, plus one long hold-off on request.
  // Outputs are read at the rising edge, before the block updates them.
  initial begin
    int      stall;
    result_t got;
    stall = 0;
    pop   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall    = 80;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        pop   = 1'b0;
        stall = stall - 1;
      end else begin
        pop   = 1'b1;
        stall = pick_gap(pop_idle_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        got.status        = status_o;
        got.rx_phase      = rx_phase_o;
        got.write_enable  = write_enable_o;
        got.write_offset  = write_offset_o;
        got.write_data    = write_data_o;
        got.write_count   = write_count_o;
        got.packet_done   = packet_done_o;
        got.endpoint      = endpoint_o;
        got.packet_length = packet_length_o;
        trk.check_result(got);
      end
    end
  end

  // Main sequence: reset, directed frames, then random phases under different
  // channel settings and idling patterns.
  initial begin
    frame_t f;
    int     k;
    rst_ni        = 1'b0;
    push          = 1'b0;
    frame_id_i    = '0;
    extended_i    = 1'b0;
    byte_count_i  = '0;
    payload_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_OWN_CHANNEL;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    send_idle_pct = 20;
    pop_idle_pct  = 20;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // still disabled after reset: filtered
    send_lead(6'd3, 16'd8, 4'd8);
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'hffff);
    write_reg(CFG_CHANNEL_ENABLE, 16'd1);

    // all id bits set: our channel, opcode above the advertisement
    f = '{id: '1, ext: 1'b1, cnt: 4'hf, payload: '1};
    send_frame(f);
    f.ext = 1'b0;                            // standard frame
    send_frame(f);
    f = own_frame(8'h00, 4'd8, 64'h0000_0008_0000_0000);
    f.id[CHAN_LSB +: CHAN_W] = 16'h1234;     // someone else's channel
    send_frame(f);
    send_lead(6'h3f, 16'hffff, 4'd8);        // length far too big
    send_lead(6'h00, 16'(MAX_PACKET_BYTES + 1), 4'd8);
    send_lead(6'h01, 16'(MAX_PACKET_BYTES), 4'd8);
    send_lead(6'h00, 16'd0, 4'd8);           // empty packet
    send_own(OP_DATA_MIN, 4'd0, '1);         // zero-byte fragment completes it
    send_own(OP_TRAIL, 4'd0, '0);
    send_own(OP_DATA_MIN, 4'd8, '1);         // data while done
    send_own(OP_TRAIL, 4'd8, '1);            // trailing while done: invalid
    send_own(OP_DATA_MIN, 4'd8, '1);         // data while invalid
    send_own(8'h05, 4'd4, '1);               // length bytes beyond the count
    send_lead(6'h2a, 16'd12, 4'hf);          // count clamped to eight
    send_own(OP_DATA_MIN + 8'd1, 4'd8, '1);  // out of order
    send_own(OP_DATA_MIN, 4'd8, '1);
    send_own(OP_DATA_MIN + 8'd1, 4'd8, '1);  // would overrun the length
    send_own(OP_DATA_MIN + 8'd1, 4'd4, '1);  // upper bytes must read as zero
    send_own(OP_DATA_MIN + 8'd2, 4'd0, '0);  // data in trailing phase
    send_own(OP_TRAIL, 4'd2, rand64());
    send_own(OP_DATA_MAX, 4'd8, '1);
    send_own(8'hc2, 4'd1, rand64());
    send_own(OP_ADV, 4'd8, rand64());        // channel conflict: lost
    send_lead(6'h07, 16'd4, 4'd8);           // filtered while lost
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'h0000);    // clears the lost flag
    send_own(8'h00, 4'd0, '0);

    // random, moderate idling on both sides
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'($urandom));
    send_idle_pct = 30;
    pop_idle_pct  = 30;
    run_packets(trk.counted + 100);

    // no idling at all, and a long hold-off on the result side while the
    // sender keeps offering items, so the block fills and raises full
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'hffff);
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    hold_req      = 1'b1;
    run_packets(trk.counted + 100);

    // channel disabled: every frame is filtered
    wait_drained();
    write_reg(CFG_CHANNEL_ENABLE, 16'd0);
    send_idle_pct = 40;
    pop_idle_pct  = 40;
    for (k = 0; k < 12; k++)
      send_own(8'($urandom), CNT_W'($urandom_range(0, 15)), rand64());

    // channel zero, heavy idling
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'h0000);
    write_reg(CFG_CHANNEL_ENABLE, 16'd1);
    send_idle_pct = 60;
    pop_idle_pct  = 60;
    run_packets(trk.counted + 100);

    // sender mostly busy, receiver stalling often
    wait_drained();
    write_reg(CFG_OWN_CHANNEL, 16'($urandom));
    send_idle_pct = 15;
    pop_idle_pct  = 50;
    run_packets(trk.counted + 100);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (trk.errors == 0 && trk.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[can_fragment_packet_reassembler_core.f]
+incdir+hw/rtl
hw/rtl/cfrm_pkg.sv
hw/rtl/cfrm_queue.sv
hw/rtl/cfrm_front.sv
hw/rtl/cfrm_back.sv
hw/rtl/can_fragment_packet_reassembler_core.sv
tb/can_fragment_packet_reassembler_core_tb.sv
